FILE: hw/rtl/dsnd_pkg.sv
// shared types, constants and the month length table for the date stepper
// no dependencies; used by dsnd_step and date_step_next_previous_day
package dsnd_pkg;

    localparam int unsigned DATE_W = 27;
    localparam int unsigned YEAR_W = 14;
    localparam int unsigned MON_W  = 4;
    localparam int unsigned DAY_W  = 5;
    localparam int unsigned RAW_W  = 7;   // two decimal digits before clamping
    localparam int unsigned CENT_W = 8;
    localparam int unsigned DIR_W  = 2;
    localparam int unsigned TDATA_W = 32;

    localparam logic [DIR_W-1:0] DIR_NONE = 2'b00;
    localparam logic [DIR_W-1:0] DIR_FWD  = 2'b01;

    localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;
    localparam logic [MON_W-1:0]  MON_JAN  = 4'd1;
    localparam logic [MON_W-1:0]  MON_FEB  = 4'd2;
    localparam logic [MON_W-1:0]  MON_APR  = 4'd4;
    localparam logic [MON_W-1:0]  MON_JUN  = 4'd6;
    localparam logic [MON_W-1:0]  MON_SEP  = 4'd9;
    localparam logic [MON_W-1:0]  MON_NOV  = 4'd11;
    localparam logic [MON_W-1:0]  MON_DEC  = 4'd12;
    localparam logic [DAY_W-1:0]  DAY_FIRST = 5'd1;
    localparam logic [DAY_W-1:0]  DAY_DEC_LAST = 5'd31;

    // reciprocals: x/10000 = (x>>4)/625, x/100 = (x>>2)/25
    localparam int unsigned DIV625_SH = 33;
    localparam logic [23:0] DIV625_MUL = 24'd13743896;
    localparam int unsigned DIV25_SH  = 16;
    localparam logic [11:0] DIV25_MUL  = 12'd2622;

    localparam logic [DATE_W-1:0] DATE_LAST = 27'd99991231;
    localparam logic [DATE_W-1:0] DATE_FIRST = 27'd101;

    // decimal fields after the split, before clamping
    typedef struct packed {
        logic [YEAR_W-1:0] year;
        logic [CENT_W-1:0] cent;   // year / 100
        logic [RAW_W-1:0]  mon;
        logic [RAW_W-1:0]  day;
        logic [DIR_W-1:0]  dir;
    } t_split;

    typedef struct packed {
        logic [YEAR_W-1:0] year;
        logic [MON_W-1:0]  mon;
        logic [DAY_W-1:0]  day;
        logic              err;
    } t_ymd;

    function automatic logic [DAY_W-1:0] month_days(input logic [MON_W-1:0] mon,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        case (mon)
            MON_FEB: len = leap ? 5'd29 : 5'd28;
            MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

FILE: hw/rtl/dsnd_step.sv
// clamps split date fields and moves the date one day forward or back, or keeps it for the none code
// depends on dsnd_pkg (types, month length table)
module dsnd_step (
    input  dsnd_pkg::t_split i_split,
    output dsnd_pkg::t_ymd   o_ymd
);
    import dsnd_pkg::*;

    logic              cent0;
    logic              leap;
    logic [MON_W-1:0]  mon;
    logic [MON_W-1:0]  mon_prev;
    logic [DAY_W-1:0]  len;
    logic [DAY_W-1:0]  day;
    logic [YEAR_W-1:0] cent_x100;

    assign cent_x100 = YEAR_W'({6'd0, i_split.cent} * 14'd100);
    assign cent0 = (cent_x100 == i_split.year);
    // gregorian rule: every fourth year, centuries only when divisible by 400
    assign leap  = cent0 ? (i_split.cent[1:0] == 2'b00) : (i_split.year[1:0] == 2'b00);

    always_comb begin
        if (i_split.mon == '0) begin
            mon = MON_JAN;
        end else if (i_split.mon > RAW_W'(MON_DEC)) begin
            mon = MON_DEC;
        end else begin
            mon = i_split.mon[MON_W-1:0];
        end
    end

    assign mon_prev = mon - MON_JAN;
    assign len = month_days(mon, leap);

    always_comb begin
        if (i_split.day == '0) begin
            day = DAY_FIRST;
        end else if (i_split.day > RAW_W'(len)) begin
            day = len;
        end else begin
            day = i_split.day[DAY_W-1:0];
        end
    end

    always_comb begin
        o_ymd.year = i_split.year;
        o_ymd.mon  = mon;
        o_ymd.day  = day;
        o_ymd.err  = 1'b0;
        if (i_split.year > YEAR_MAX) begin
            o_ymd.year = YEAR_MAX;
            o_ymd.mon  = MON_DEC;
            o_ymd.day  = DAY_DEC_LAST;
            o_ymd.err  = 1'b1;
        end else if (i_split.dir == DIR_FWD) begin
            if (day < len) begin
                o_ymd.day = day + DAY_FIRST;
            end else if (mon < MON_DEC) begin
                o_ymd.mon = mon + MON_JAN;
                o_ymd.day = DAY_FIRST;
            end else if (i_split.year < YEAR_MAX) begin
                o_ymd.year = i_split.year + 14'd1;
                o_ymd.mon  = MON_JAN;
                o_ymd.day  = DAY_FIRST;
            end else begin
                o_ymd.err = 1'b1;
            end
        end else if (i_split.dir[1]) begin
            // both negative codes step back
            if (day > DAY_FIRST) begin
                o_ymd.day = day - DAY_FIRST;
            end else if (mon > MON_JAN) begin
                o_ymd.mon = mon_prev;
                o_ymd.day = month_days(mon_prev, leap);
            end else if (i_split.year != '0) begin
                o_ymd.year = i_split.year - 14'd1;
                o_ymd.mon  = MON_DEC;
                o_ymd.day  = DAY_DEC_LAST;
            end else begin
                o_ymd.err = 1'b1;
            end
        end
    end

endmodule

FILE: hw/rtl/date_step_next_previous_day.sv
// channel  dir  tdata bits (low first)                         last  user
// s        in   packed_date[26:0], step_dir[28:27], zero[31:29]  -     -
// m        out  new_date[26:0], range_error[27], zero[31:28]      -     -
//
// one item per cycle sustained while m does not stall; the result passes through
// the six register stages (input, decimal split, step and repack)
// reset clears only the stage valid bits; payload registers are not reset
// a stall on m holds the full stages; empty stages keep filling, so s stays
// ready until all six stages hold an item
// depends on dsnd_pkg and dsnd_step
module date_step_next_previous_day (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [dsnd_pkg::TDATA_W-1:0]   i_s_tdata,   // packed_date, step_dir
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [dsnd_pkg::TDATA_W-1:0]   o_m_tdata    // new_date, range_error
);
    import dsnd_pkg::*;

    localparam int unsigned NSTG = 6;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_vld;
    logic [NSTG-1:0] load;

    logic [DATE_W-1:0] r1_date;
    logic [DIR_W-1:0]  r1_dir;
    logic [DATE_W-1:0] r2_date;
    logic [DIR_W-1:0]  r2_dir;
    logic [YEAR_W-1:0] r2_year;
    logic [YEAR_W-1:0] r3_year;
    logic [YEAR_W-1:0] r3_rem;
    logic [DIR_W-1:0]  r3_dir;
    t_split            r4_split;
    t_ymd              r5_ymd;
    logic [DATE_W-1:0] r6_date;
    logic              r6_err;

    logic [46:0]       n_yprod;
    logic [DATE_W-1:0] n_rem;
    logic [23:0]       n_mprod;
    logic [23:0]       n_cprod;
    logic [RAW_W-1:0]  n_mon;
    logic [YEAR_W-1:0] n_day;
    t_split            n_split;
    t_ymd              n_ymd;
    logic [DATE_W-1:0] n_date;

    // a stage loads when it is empty or its content moves on
    always_comb begin
        load[NSTG-1] = !r_vld[NSTG-1] || i_m_tready;
        for (int i = NSTG - 2; i >= 0; i--) begin
            load[i] = !r_vld[i] || load[i+1];
        end
        n_vld = r_vld;
        if (load[0]) begin
            n_vld[0] = i_s_tvalid;
        end
        for (int i = 1; i < NSTG; i++) begin
            if (load[i]) begin
                n_vld[i] = r_vld[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // year = date / 10000
    assign n_yprod = 47'(r1_date[DATE_W-1:4]) * 47'(DIV625_MUL);
    // remainder below 10000
    assign n_rem = r2_date - DATE_W'(r2_year) * DATE_W'(10000);
    // month digits = rem / 100, century = year / 100
    assign n_mprod = 24'(r3_rem[YEAR_W-1:2]) * 24'(DIV25_MUL);
    assign n_cprod = 24'(r3_year[YEAR_W-1:2]) * 24'(DIV25_MUL);
    assign n_mon   = n_mprod[DIV25_SH +: RAW_W];
    assign n_day   = r3_rem - YEAR_W'(n_mon) * YEAR_W'(100);

    always_comb begin
        n_split.year = r3_year;
        n_split.cent = n_cprod[DIV25_SH +: CENT_W];
        n_split.mon  = n_mon;
        n_split.day  = n_day[RAW_W-1:0];
        n_split.dir  = r3_dir;
    end

    dsnd_step u_step (
        .i_split (r4_split),
        .o_ymd   (n_ymd)
    );

    assign n_date = DATE_W'(r5_ymd.year) * DATE_W'(10000)
                  + DATE_W'(r5_ymd.mon) * DATE_W'(100)
                  + DATE_W'(r5_ymd.day);

    always_ff @(posedge i_clk) begin
        if (load[0]) begin
            r1_date <= i_s_tdata[DATE_W-1:0];
            r1_dir  <= i_s_tdata[DATE_W +: DIR_W];
        end
        if (load[1]) begin
            r2_date <= r1_date;
            r2_dir  <= r1_dir;
            r2_year <= n_yprod[DIV625_SH +: YEAR_W];
        end
        if (load[2]) begin
            r3_year <= r2_year;
            r3_rem  <= n_rem[YEAR_W-1:0];
            r3_dir  <= r2_dir;
        end
        if (load[3]) begin
            r4_split <= n_split;
        end
        if (load[4]) begin
            r5_ymd <= n_ymd;
        end
        if (load[5]) begin
            r6_date <= n_date;
            r6_err  <= r5_ymd.err;
        end
    end

    assign o_s_tready = load[0];
    assign o_m_tvalid = r_vld[NSTG-1];
    assign o_m_tdata  = {{(TDATA_W - DATE_W - 1){1'b0}}, r6_err, r6_date};

    // input is refused only when every stage is occupied
    a_full_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (&r_vld))
        else $error("input refused with an empty stage");

    // a range error leaves the date clamped at one end of the calendar
    a_err_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[DATE_W] |->
            (o_m_tdata[DATE_W-1:0] == DATE_LAST || o_m_tdata[DATE_W-1:0] == DATE_FIRST))
        else $error("range error on an unclamped date");

    // results never pass the last representable date
    a_date_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[DATE_W-1:0] <= DATE_LAST))
        else $error("result date out of range");

    // an item in the step stage reaches the output stage next cycle unless stalled
    a_step_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NSTG-2] && load[NSTG-2] |=> r_vld[NSTG-1])
        else $error("item lost between step and output stages");

endmodule

FILE: tb/sv/testbench.sv
// testbench for date_step_next_previous_day: directed and random dates through the stream ports
// predicts each stepped date itself and checks results in order
// depends on dsnd_pkg and the date_step_next_previous_day rtl
`timescale 1ns / 1ps

module testbench;
    import dsnd_pkg::*;

    localparam logic [DIR_W-1:0] DIR_BACK     = 2'b11;
    localparam logic [DIR_W-1:0] DIR_BACK_ALT = 2'b10;   // unused code, acts as back
    localparam int unsigned PIPE_CYCLES = 6;
    localparam int unsigned DRAIN_LIMIT = 200000;

    typedef struct packed {
        logic [DATE_W-1:0] new_date;
        logic              range_error;
    } t_date_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               s_tvalid;
    logic               o_s_tready;
    logic [TDATA_W-1:0] s_tdata;    // packed_date, step_dir
    logic               o_m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] o_m_tdata;  // new_date, range_error

    t_date_result expected_dates[$];
    int unsigned  error_count;
    int unsigned  sent_count;
    int unsigned  checked_count;
    int unsigned  clamp_count;
    int unsigned  directed_count;
    bit           idle_en;

    date_step_next_previous_day dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int unsigned month_length(input int unsigned yr, input int unsigned mo);
        bit leap;
        leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
        case (mo)
            MON_FEB: return leap ? 29 : 28;
            MON_APR, MON_JUN, MON_SEP, MON_NOV: return 30;
            default: return 31;
        endcase
    endfunction

    function automatic t_date_result predict_stepped_date(input logic [DATE_W-1:0] date,
                                                          input logic [DIR_W-1:0] dir);
        int unsigned  raw;
        int unsigned  yr;
        int unsigned  mo;
        int unsigned  dy;
        int unsigned  len;
        t_date_result res;
        raw = date;
        yr  = raw / 10000;
        mo  = (raw / 100) % 100;
        dy  = raw % 100;
        res.range_error = 1'b0;
        if (yr > YEAR_MAX) begin
            res.new_date    = DATE_LAST;
            res.range_error = 1'b1;
            return res;
        end
        // malformed month and day are pulled into range before stepping
        if (mo < MON_JAN) mo = MON_JAN;
        if (mo > MON_DEC) mo = MON_DEC;
        len = month_length(yr, mo);
        if (dy < DAY_FIRST) dy = DAY_FIRST;
        if (dy > len) dy = len;
        if (dir == DIR_FWD) begin
            if (dy < len) begin
                dy++;
            end else if (mo < MON_DEC) begin
                mo++;
                dy = DAY_FIRST;
            end else if (yr < YEAR_MAX) begin
                yr++;
                mo = MON_JAN;
                dy = DAY_FIRST;
            end else begin
                res.range_error = 1'b1;
            end
        end else if (dir[DIR_W-1]) begin
            if (dy > DAY_FIRST) begin
                dy--;
            end else if (mo > MON_JAN) begin
                mo--;
                dy = month_length(yr, mo);
            end else if (yr > 0) begin
                yr--;
                mo = MON_DEC;
                dy = DAY_DEC_LAST;
            end else begin
                res.range_error = 1'b1;
            end
        end
        res.new_date = DATE_W'(yr * 10000 + mo * 100 + dy);
        return res;
    endfunction

    task automatic send_date(input logic [DATE_W-1:0] date, input logic [DIR_W-1:0] dir);
        int unsigned gap;
        gap = idle_en ? $urandom_range(0, 16) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(TDATA_W - DATE_W - DIR_W){1'b0}}, dir, date};
        do @(posedge i_clk); while (!o_s_tready);
        expected_dates.push_back(predict_stepped_date(date, dir));
        sent_count++;
    endtask

    function automatic logic [DIR_W-1:0] random_dir();
        return DIR_W'($urandom_range(0, 3));
    endfunction

    // well-formed date, optionally pushed toward month, year and range ends
    function automatic logic [DATE_W-1:0] random_valid_date(input bit near_end);
        int unsigned yr;
        int unsigned mo;
        int unsigned dy;
        int unsigned len;
        case ($urandom_range(0, 7))
            0: yr = 0;
            1: yr = YEAR_MAX;
            2: yr = $urandom_range(0, 99) * 100;
            3: yr = $urandom_range(0, 24) * 400;
            default: yr = $urandom_range(0, YEAR_MAX);
        endcase
        mo  = near_end && $urandom_range(0, 1) ? ($urandom_range(0, 1) ? MON_DEC : MON_JAN)
                                                : $urandom_range(MON_JAN, MON_DEC);
        len = month_length(yr, mo);
        if (near_end) begin
            case ($urandom_range(0, 3))
                0: dy = DAY_FIRST;
                1: dy = len;
                2: dy = len - 1;
                default: dy = DAY_FIRST + 1;
            endcase
        end else begin
            dy = $urandom_range(DAY_FIRST, len);
        end
        return DATE_W'(yr * 10000 + mo * 100 + dy);
    endfunction

    // results check against the oldest prediction
    always @(posedge i_clk) begin
        t_date_result want;
        t_date_result got;
        if (i_rst_n && o_m_tvalid && m_tready) begin
            got.new_date    = o_m_tdata[DATE_W-1:0];
            got.range_error = o_m_tdata[DATE_W];
            if (expected_dates.size() == 0) begin
                $display("%0t: unexpected result new_date=%0d range_error=%0b",
                         $time, got.new_date, got.range_error);
                error_count++;
            end else begin
                want = expected_dates.pop_front();
                checked_count++;
                if (got.range_error) clamp_count++;
                if (got.new_date !== want.new_date) begin
                    $display("%0t: new_date mismatch expected %0d actual %0d",
                             $time, want.new_date, got.new_date);
                    error_count++;
                end
                if (got.range_error !== want.range_error) begin
                    $display("%0t: range_error mismatch expected %0b actual %0b",
                             $time, want.range_error, got.range_error);
                    error_count++;
                end
            end
        end
    end

    // receiver side back-pressure, a fresh stall for every item
    initial begin
        int unsigned stall;
        m_tready = 1'b0;
        wait (i_rst_n);
        forever begin
            stall = idle_en ? $urandom_range(0, 16) : 0;
            if (stall > 0) begin
                @(negedge i_clk);
                m_tready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!(o_m_tvalid && m_tready));
        end
    end

    task automatic test_directed();
        idle_en = 1'b1;
        send_date(DATE_FIRST, DIR_BACK);         // step before the first date
        send_date(DATE_LAST, DIR_FWD);           // step past the last date
        send_date(DATE_LAST, DIR_BACK);
        send_date(DATE_FIRST, DIR_FWD);
        send_date({DATE_W{1'b1}}, DIR_NONE);     // year above the top
        send_date({DATE_W{1'b1}}, DIR_FWD);
        send_date(27'd100000000, DIR_BACK);
        send_date(27'd0, DIR_NONE);              // month and day zero
        send_date(27'd20231399, DIR_NONE);       // month above twelve, day too big
        send_date(27'd99999999, DIR_FWD);
        send_date(27'd20230431, DIR_NONE);       // day beyond month length
        send_date(27'd20230230, DIR_NONE);
        send_date(27'd20240229, DIR_FWD);        // leap february
        send_date(27'd20230228, DIR_FWD);
        send_date(27'd19000228, DIR_FWD);        // century, not leap
        send_date(27'd20000228, DIR_FWD);        // fourth century, leap
        send_date(27'd20240301, DIR_BACK);
        send_date(27'd19000301, DIR_BACK);
        send_date(27'd20000301, DIR_BACK_ALT);   // unused code acts as back
        send_date(27'd20231231, DIR_FWD);        // year rollover
        send_date(27'd20240101, DIR_BACK_ALT);
        send_date(27'd00000229, DIR_FWD);        // year zero is leap
        send_date(27'd10000101, DIR_BACK);
        send_date(27'd20230615, DIR_NONE);
        directed_count = sent_count;
    endtask

    task automatic test_random_dates(input int unsigned count);
        for (int unsigned i = 0; i < count; i++) begin
            if (i % 50 == 0) idle_en = ($urandom_range(0, 3) != 0);
            send_date(random_valid_date(1'b0), random_dir());
        end
    endtask

    task automatic test_boundary_dates(input int unsigned count);
        for (int unsigned i = 0; i < count; i++) begin
            if (i % 50 == 0) idle_en = ($urandom_range(0, 3) != 0);
            send_date(random_valid_date(1'b1), random_dir());
        end
    endtask

    // raw field values, malformed dates and years above the top included
    task automatic test_raw_fields(input int unsigned count);
        for (int unsigned i = 0; i < count; i++) begin
            if (i % 50 == 0) idle_en = ($urandom_range(0, 3) != 0);
            send_date(DATE_W'($urandom()), random_dir());
        end
    endtask

    task automatic drain_results();
        int unsigned waited;
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        waited = 0;
        while (expected_dates.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (PIPE_CYCLES + 4) @(posedge i_clk);
        if (expected_dates.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, expected_dates.size());
            error_count += expected_dates.size();
        end
    endtask

    initial begin
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        idle_en  = 1'b1;
        error_count = 0;
        sent_count = 0;
        checked_count = 0;
        clamp_count = 0;
        directed_count = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random_dates(1000);
        test_boundary_dates(400);
        test_raw_fields(300);
        drain_results();

        $display("sent %0d dates (%0d directed), checked %0d results",
                 sent_count, directed_count, checked_count);
        $display("%0d results were clamped with range error", clamp_count);
        if (error_count == 0) begin
            $display("PASS date_step_next_previous_day");
        end else begin
            $display("FAIL date_step_next_previous_day");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("timeout at %0t", $time);
        $display("FAIL date_step_next_previous_day");
        $finish;
    end

endmodule

FILE: date_step_next_previous_day.f
hw/rtl/dsnd_pkg.sv
hw/rtl/dsnd_step.sv
hw/rtl/date_step_next_previous_day.sv
tb/sv/testbench.sv
